### src/bdpi_pkg.sv
// Package for the banked deque unit: sizes, result codes and the
// controller/datapath handshake structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bdpi_pkg;

    localparam int NUM_QUEUES  = 32;
    localparam int QUEUE_DEPTH = 8;
    localparam int TAG_BITS    = 16;

    // fixed field widths of the request and result items
    localparam int OP_W        = 1;
    localparam int QINDEX_W    = 5;
    localparam int ENTRY_TAG_W = 16;
    localparam int CODE_W      = 2;
    localparam int NEW_COUNT_W = 4;

    // internal widths
    localparam int SLOT_COUNT = NUM_QUEUES * QUEUE_DEPTH;
    localparam int QI_W       = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int HD_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;
    localparam int ADDR_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int WORD_W     = TAG_BITS + 1;

    localparam logic [OP_W-1:0] OP_ADD  = 1'b0;
    localparam logic [OP_W-1:0] OP_TAKE = 1'b1;

    typedef enum logic [CODE_W-1:0] {
        RC_ADDED = 2'd0,
        RC_FULL  = 2'd1,
        RC_TAKEN = 2'd2,
        RC_EMPTY = 2'd3
    } bdpi_code_t;

    typedef struct packed {
        logic capture;
        logic commit;
        logic load_direct;
        logic load_read;
    } bdpi_cmd_t;

    typedef struct packed {
        logic needs_read;
    } bdpi_sts_t;

endpackage

`default_nettype wire

### src/bdpi_req_if.sv
// Request channel: valid/ready handshake carrying one queue operation.
// Depends on bdpi_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bdpi_req_if
    import bdpi_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        operation;
    logic [QINDEX_W-1:0]    queue_index;
    logic [ENTRY_TAG_W-1:0] entry_tag;
    logic                   urgent;

    modport source (output valid, operation, queue_index, entry_tag, urgent, input ready);
    modport sink   (input valid, operation, queue_index, entry_tag, urgent, output ready);
endinterface

`default_nettype wire

### src/bdpi_rsp_if.sv
// Result channel: valid/ready handshake carrying one operation outcome.
// Depends on bdpi_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bdpi_rsp_if
    import bdpi_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CODE_W-1:0]      result_code;
    logic [ENTRY_TAG_W-1:0] taken_tag;
    logic                   taken_urgent;
    logic [NEW_COUNT_W-1:0] new_count;

    modport source (output valid, result_code, taken_tag, taken_urgent, new_count, input ready);
    modport sink   (input valid, result_code, taken_tag, taken_urgent, new_count, output ready);
endinterface

`default_nettype wire

### src/banked_deque_priority_insert_unit.sv
// Adds and refused requests pass through the request latch and the result
// register; a take that finds an entry also reads the entry memory first.
// One request at a time: the controller steps each request through the
// single-port entry memory and takes the next once its result is loaded.
// Reset clears all queue counts and heads; the entry memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module banked_deque_priority_insert_unit
    import bdpi_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    bdpi_req_if.sink    req,
    bdpi_rsp_if.source  rsp
);

    bdpi_cmd_t cmd;
    bdpi_sts_t sts;

    bdpi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bdpi_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .operation    (req.operation),
        .queue_index  (req.queue_index),
        .entry_tag    (req.entry_tag),
        .urgent       (req.urgent),
        .result_code  (rsp.result_code),
        .taken_tag    (rsp.taken_tag),
        .taken_urgent (rsp.taken_urgent),
        .new_count    (rsp.new_count)
    );

endmodule

`default_nettype wire

### src/bdpi_ctrl.sv
// Controller state machine: sequences capture, update, entry read and
// result load. Depends on bdpi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdpi_ctrl
    import bdpi_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    input  wire bdpi_sts_t sts,
    output bdpi_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.needs_read)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_READ;
                end
                else if (out_free)
                begin
                    cmd.commit      = 1'b1;
                    cmd.load_direct = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    cmd.load_read = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        priority if (cmd.load_direct || cmd.load_read)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

### src/bdpi_datapath.sv
// Datapath: request latch, per-queue count and head registers, entry
// memory and result register. Depends on bdpi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdpi_datapath
    import bdpi_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire bdpi_cmd_t              cmd,
    output bdpi_sts_t                   sts,
    input  wire logic [OP_W-1:0]        operation,
    input  wire logic [QINDEX_W-1:0]    queue_index,
    input  wire logic [ENTRY_TAG_W-1:0] entry_tag,
    input  wire logic                   urgent,
    output logic [CODE_W-1:0]           result_code,
    output logic [ENTRY_TAG_W-1:0]      taken_tag,
    output logic                        taken_urgent,
    output logic [NEW_COUNT_W-1:0]      new_count
);

    logic [OP_W-1:0]     op_reg;
    logic [QINDEX_W-1:0] qidx_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic                urg_reg;

    logic [CNT_W-1:0] count_reg [NUM_QUEUES];
    logic [HD_W-1:0]  head_reg  [NUM_QUEUES];
    logic [WORD_W-1:0] mem [SLOT_COUNT];
    logic [WORD_W-1:0] rd_data_reg;

    bdpi_code_t       pend_code_reg;
    logic [CNT_W-1:0] pend_count_reg;

    logic [CODE_W-1:0]      code_out_reg;
    logic [ENTRY_TAG_W-1:0] tag_out_reg;
    logic                   urg_out_reg;
    logic [NEW_COUNT_W-1:0] count_out_reg;

    logic [QI_W-1:0]   qi;
    logic              in_range;
    logic [CNT_W-1:0]  cnt;
    logic [HD_W-1:0]   head;
    logic              full;
    logic              empty;
    logic              add_hit;
    logic              take_hit;
    logic [HD_W-1:0]   head_dec;
    logic [HD_W-1:0]   head_inc;
    logic [SUM_W-1:0]  tail_sum;
    logic [HD_W-1:0]   tail;
    logic [HD_W-1:0]   slot;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  cnt_after;
    bdpi_code_t        code;

    assign qi       = QI_W'(qidx_reg);
    assign in_range = (32'(qidx_reg) < 32'(NUM_QUEUES));
    assign cnt      = in_range ? count_reg[qi] : '0;
    assign head     = head_reg[qi];
    assign full     = (cnt >= CNT_W'(QUEUE_DEPTH));
    assign empty    = (cnt == '0);
    assign add_hit  = (op_reg == OP_ADD) && in_range && !full;
    assign take_hit = (op_reg == OP_TAKE) && in_range && !empty;

    assign head_dec = (head == '0) ? HD_W'(QUEUE_DEPTH - 1) : head - HD_W'(1);
    assign head_inc = (head == HD_W'(QUEUE_DEPTH - 1)) ? '0 : head + HD_W'(1);
    assign tail_sum = SUM_W'(head) + SUM_W'(cnt);
    assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                      ? HD_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : HD_W'(tail_sum);

    always_comb
    begin
        priority if (op_reg == OP_TAKE)
            slot = head;
        else if (urg_reg)
            slot = head_dec;
        else
            slot = tail;
    end

    assign addr = ADDR_W'(ADDR_W'(qi) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(slot);

    always_comb
    begin
        priority if (add_hit)
            cnt_after = cnt + CNT_W'(1);
        else if (take_hit)
            cnt_after = cnt - CNT_W'(1);
        else
            cnt_after = cnt;
    end

    always_comb
    begin
        if (op_reg == OP_ADD)
            code = add_hit ? RC_ADDED : RC_FULL;
        else
            code = take_hit ? RC_TAKEN : RC_EMPTY;
    end

    assign sts.needs_read = take_hit;

    // latch the accepted request
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= operation;
            qidx_reg <= queue_index;
            tag_reg  <= TAG_BITS'(entry_tag);
            urg_reg  <= urgent;
        end
    end

    // per-queue count and head
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                count_reg[i] <= '0;
                head_reg[i]  <= '0;
            end
        end
        else if (cmd.commit)
        begin
            if (add_hit)
            begin
                count_reg[qi] <= cnt_after;
                if (urg_reg)
                    head_reg[qi] <= head_dec;
            end
            else if (take_hit)
            begin
                count_reg[qi] <= cnt_after;
                head_reg[qi]  <= head_inc;
            end
        end
    end

    // entry memory: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.commit && add_hit)
            mem[addr] <= {urg_reg, tag_reg};
        if (cmd.commit && take_hit)
            rd_data_reg <= mem[addr];
    end

    // hold outcome of a take across the memory read
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            pend_code_reg  <= code;
            pend_count_reg <= cnt_after;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_direct)
        begin
            code_out_reg  <= code;
            tag_out_reg   <= '0;
            urg_out_reg   <= 1'b0;
            count_out_reg <= NEW_COUNT_W'(cnt_after);
        end
        else if (cmd.load_read)
        begin
            code_out_reg  <= pend_code_reg;
            tag_out_reg   <= ENTRY_TAG_W'(rd_data_reg[TAG_BITS-1:0]);
            urg_out_reg   <= rd_data_reg[TAG_BITS];
            count_out_reg <= NEW_COUNT_W'(pend_count_reg);
        end
    end

    assign result_code  = code_out_reg;
    assign taken_tag    = tag_out_reg;
    assign taken_urgent = urg_out_reg;
    assign new_count    = count_out_reg;

endmodule

`default_nettype wire

### src/bdpi_checker.sv
// Port-level checks on the result channel of the banked deque unit, and the
// bind that attaches them to the top level. Depends on bdpi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdpi_checker
    import bdpi_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   rsp_valid,
    input wire logic                   rsp_ready,
    input wire logic [CODE_W-1:0]      result_code,
    input wire logic [ENTRY_TAG_W-1:0] taken_tag,
    input wire logic                   taken_urgent,
    input wire logic [NEW_COUNT_W-1:0] new_count
);

    a_no_tag_unless_taken: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (result_code != RC_TAKEN) |-> (taken_tag == '0) && !taken_urgent)
        else $error("tag reported without a take");

    a_empty_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (result_code == RC_EMPTY) |-> (new_count == '0))
        else $error("empty result with nonzero count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (result_code == RC_FULL)
        |-> (new_count == NEW_COUNT_W'(QUEUE_DEPTH)) || (new_count == '0))
        else $error("full result with partial count");

    a_added_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (result_code == RC_ADDED) |-> (new_count != '0)
            || (NEW_COUNT_W'(QUEUE_DEPTH) == '0))
        else $error("added result with zero count");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_code))
        else $error("result dropped while stalled");

endmodule

bind banked_deque_priority_insert_unit bdpi_checker u_bdpi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .result_code  (rsp.result_code),
    .taken_tag    (rsp.taken_tag),
    .taken_urgent (rsp.taken_urgent),
    .new_count    (rsp.new_count)
);

`default_nettype wire
